### hw/rtl/lli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lli_pkg
// Shared constants of the two-line intersection core.
// ----------------------------------------------------------------------------
package lli_pkg;

	// fractional bits carried by the line-one parameter t
	localparam int T_FRAC_BITS = 32;
	// partial products for t times a direction component
	localparam int NUM_CHUNKS = 3;

endpackage

### hw/rtl/lli_query_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lli_query_if
// Valid/ready channel carrying the two lines of one query.
// ----------------------------------------------------------------------------
interface lli_query_if #(
	parameter int COORD_WIDTH = 32
);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] l1a_x;
	logic signed [COORD_WIDTH-1:0] l1a_y;
	logic signed [COORD_WIDTH-1:0] l1b_x;
	logic signed [COORD_WIDTH-1:0] l1b_y;
	logic signed [COORD_WIDTH-1:0] l2a_x;
	logic signed [COORD_WIDTH-1:0] l2a_y;
	logic signed [COORD_WIDTH-1:0] l2b_x;
	logic signed [COORD_WIDTH-1:0] l2b_y;

	modport source (
		output valid, l1a_x, l1a_y, l1b_x, l1b_y, l2a_x, l2a_y, l2b_x, l2b_y,
		input  ready
	);
	modport sink (
		input  valid, l1a_x, l1a_y, l1b_x, l1b_y, l2a_x, l2a_y, l2b_x, l2b_y,
		output ready
	);
endinterface

### hw/rtl/lli_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lli_result_if
// Valid/ready channel carrying one intersection result.
// ----------------------------------------------------------------------------
interface lli_result_if #(
	parameter int COORD_WIDTH = 32
);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] cross_x;
	logic signed [COORD_WIDTH-1:0] cross_y;
	logic is_parallel;
	logic overflowed;

	modport source (
		output valid, cross_x, cross_y, is_parallel, overflowed,
		input  ready
	);
	modport sink (
		input  valid, cross_x, cross_y, is_parallel, overflowed,
		output ready
	);
endinterface

### hw/rtl/line_line_intersection_core.sv
`timescale 1ns / 1ps
// Pipeline: 8 + (2*COORD_WIDTH + 35) register stages to the output register (107 at 32 bits),
// followed by the output register; the restoring divider retires one quotient bit per stage.
// Throughput: one transfer per cycle while the skid register is empty.
// Reset: arst_n clears all valid bits, including those of the output and skid registers; payload is not reset.
// ----------------------------------------------------------------------------
// line_line_intersection_core
// Intersection point of two lines given by point pairs, pipelined with a
// bit-per-stage divider, chunked t*d multiply and saturating output.
// ----------------------------------------------------------------------------
module line_line_intersection_core #(
	parameter int COORD_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	lli_query_if.sink    query,
	lli_result_if.source result
);
	localparam int W      = COORD_WIDTH;
	localparam int DW     = W + 1;
	localparam int PW     = 2 * W + 2;
	localparam int NW     = 2 * W + 3;
	localparam int TF     = lli_pkg::T_FRAC_BITS;
	localparam int NB     = NW + TF;
	localparam int NC     = lli_pkg::NUM_CHUNKS;
	localparam int CH     = (NB + NC - 1) / NC;
	localparam int TW     = NC * CH;
	localparam int SW     = TW + DW;
	localparam int MW     = SW - TF;
	localparam int AW     = MW + 2;
	localparam int SIDE_W = 2 * W + 2 * DW + 3;

	logic en;
	logic deliver;

	// stage 1: differences
	logic v_s1;
	logic signed [W-1:0]  x1_s1, y1_s1;
	logic signed [DW-1:0] d1x_s1, d1y_s1, d2x_s1, d2y_s1, ex_s1, ey_s1;
	// stage 2: products
	logic v_s2;
	logic signed [W-1:0]  x1_s2, y1_s2;
	logic signed [DW-1:0] d1x_s2, d1y_s2;
	logic signed [PW-1:0] p1_s2, p2_s2, p3_s2, p4_s2;
	// stage 3: denominator and numerator
	logic v_s3;
	logic signed [W-1:0]  x1_s3, y1_s3;
	logic signed [DW-1:0] d1x_s3, d1y_s3;
	logic signed [NW-1:0] den_s3, num_s3;
	// stage 4: magnitudes and signs
	logic v_s4;
	logic [NW-1:0]     denm_s4, numm_s4;
	logic [SIDE_W-1:0] side_s4;
	// divider stages
	logic              dv_v_sd    [NB];
	logic [NW-1:0]     dv_den_sd  [NB];
	logic [NW-1:0]     dv_num_sd  [NB];
	logic [NW-1:0]     dv_rem_sd  [NB];
	logic [NB-1:0]     dv_q_sd    [NB];
	logic [SIDE_W-1:0] dv_side_sd [NB];
	// stage 5..8: t*d1 and the final add
	logic v_s5, v_s6, v_s7, v_s8;
	logic signed [W-1:0] x1_s5, y1_s5, x1_s6, y1_s6, x1_s7, y1_s7;
	logic xn_s5, yn_s5, par_s5, xn_s6, yn_s6, par_s6, xn_s7, yn_s7, par_s7, par_s8;
	logic [CH+DW-1:0] pax_s5 [NC];
	logic [CH+DW-1:0] pay_s5 [NC];
	logic [CH+DW-1:0] pax2_s6, pay2_s6;
	logic [SW-1:0]    sx_s6, sy_s6, sx_s7, sy_s7;
	logic signed [AW-1:0] px_s8, py_s8;
	// output register and skid
	logic o_v_q, sk_v_q;
	logic signed [W-1:0] o_cx_q, o_cy_q, sk_cx_q, sk_cy_q;
	logic o_par_q, o_ovf_q, sk_par_q, sk_ovf_q;

	assign en          = !sk_v_q;
	assign query.ready = en;
	assign deliver     = v_s8 && en;

	// ---------------- stage 1 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= query.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= dv_v_sd[NB-1];
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1  <= query.l1a_x;
			y1_s1  <= query.l1a_y;
			d1x_s1 <= {query.l1b_x[W-1], query.l1b_x} - {query.l1a_x[W-1], query.l1a_x};
			d1y_s1 <= {query.l1b_y[W-1], query.l1b_y} - {query.l1a_y[W-1], query.l1a_y};
			d2x_s1 <= {query.l2b_x[W-1], query.l2b_x} - {query.l2a_x[W-1], query.l2a_x};
			d2y_s1 <= {query.l2b_y[W-1], query.l2b_y} - {query.l2a_y[W-1], query.l2a_y};
			ex_s1  <= {query.l2a_x[W-1], query.l2a_x} - {query.l1a_x[W-1], query.l1a_x};
			ey_s1  <= {query.l2a_y[W-1], query.l2a_y} - {query.l1a_y[W-1], query.l1a_y};
		end
	end

	// ---------------- stage 2 ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			x1_s2  <= x1_s1;
			y1_s2  <= y1_s1;
			d1x_s2 <= d1x_s1;
			d1y_s2 <= d1y_s1;
			p1_s2  <= d2x_s1 * d1y_s1;
			p2_s2  <= d1x_s1 * d2y_s1;
			p3_s2  <= d2x_s1 * ey_s1;
			p4_s2  <= d2y_s1 * ex_s1;
		end
	end

	// ---------------- stage 3 ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			x1_s3  <= x1_s2;
			y1_s3  <= y1_s2;
			d1x_s3 <= d1x_s2;
			d1y_s3 <= d1y_s2;
			den_s3 <= {p1_s2[PW-1], p1_s2} - {p2_s2[PW-1], p2_s2};
			num_s3 <= {p3_s2[PW-1], p3_s2} - {p4_s2[PW-1], p4_s2};
		end
	end

	// ---------------- stage 4 ----------------
	logic          tneg_c;
	logic [DW-1:0] d1xm_c, d1ym_c;

	assign tneg_c = num_s3[NW-1] ^ den_s3[NW-1];
	assign d1xm_c = d1x_s3[DW-1] ? (~d1x_s3 + 1'b1) : d1x_s3;
	assign d1ym_c = d1y_s3[DW-1] ? (~d1y_s3 + 1'b1) : d1y_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			denm_s4 <= den_s3[NW-1] ? (~den_s3 + 1'b1) : den_s3;
			numm_s4 <= num_s3[NW-1] ? (~num_s3 + 1'b1) : num_s3;
			side_s4 <= {x1_s3, y1_s3, d1xm_c, d1ym_c,
				tneg_c ^ d1x_s3[DW-1], tneg_c ^ d1y_s3[DW-1], den_s3 == '0};
		end
	end

	// ---------------- restoring divider, one quotient bit per stage ----------------
	for (genvar k = 0; k < NB; k++) begin : g_div
		localparam int BI = NB - 1 - k;
		logic              v_in;
		logic [NW-1:0]     den_in, num_in, rem_in;
		logic [NB-1:0]     q_in;
		logic [SIDE_W-1:0] side_in;
		logic              nbit;
		logic [NW:0]       rem_sh;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_in    = v_s4;
			assign den_in  = denm_s4;
			assign num_in  = numm_s4;
			assign rem_in  = '0;
			assign q_in    = '0;
			assign side_in = side_s4;
		end else begin : g_next
			assign v_in    = dv_v_sd[k-1];
			assign den_in  = dv_den_sd[k-1];
			assign num_in  = dv_num_sd[k-1];
			assign rem_in  = dv_rem_sd[k-1];
			assign q_in    = dv_q_sd[k-1];
			assign side_in = dv_side_sd[k-1];
		end

		if (BI >= TF) begin : g_nbit
			assign nbit = num_in[BI-TF];
		end else begin : g_zbit
			assign nbit = 1'b0;
		end

		assign rem_sh = {rem_in, nbit};
		assign ge     = rem_sh >= {1'b0, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_sd[k] <= 1'b0;
			end else if (en) begin
				dv_v_sd[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_den_sd[k]  <= den_in;
				dv_num_sd[k]  <= num_in;
				dv_rem_sd[k]  <= ge ? NW'(rem_sh - {1'b0, den_in}) : rem_sh[NW-1:0];
				dv_q_sd[k]    <= {q_in[NB-2:0], ge};
				dv_side_sd[k] <= side_in;
			end
		end
	end

	// ---------------- stage 5: partial products ----------------
	logic [TW-1:0]     t_c;
	logic [SIDE_W-1:0] side_c;

	assign t_c    = TW'(dv_q_sd[NB-1]);
	assign side_c = dv_side_sd[NB-1];

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s5  <= side_c[3+2*DW+W +: W];
			y1_s5  <= side_c[3+2*DW +: W];
			xn_s5  <= side_c[2];
			yn_s5  <= side_c[1];
			par_s5 <= side_c[0];
			for (int j = 0; j < NC; j++) begin
				pax_s5[j] <= t_c[j*CH +: CH] * side_c[3+DW +: DW];
				pay_s5[j] <= t_c[j*CH +: CH] * side_c[3 +: DW];
			end
		end
	end

	// ---------------- stage 6 and 7: accumulate ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			x1_s6   <= x1_s5;
			y1_s6   <= y1_s5;
			xn_s6   <= xn_s5;
			yn_s6   <= yn_s5;
			par_s6  <= par_s5;
			sx_s6   <= SW'(pax_s5[0]) + (SW'(pax_s5[1]) << CH);
			sy_s6   <= SW'(pay_s5[0]) + (SW'(pay_s5[1]) << CH);
			pax2_s6 <= pax_s5[NC-1];
			pay2_s6 <= pay_s5[NC-1];
			x1_s7   <= x1_s6;
			y1_s7   <= y1_s6;
			xn_s7   <= xn_s6;
			yn_s7   <= yn_s6;
			par_s7  <= par_s6;
			sx_s7   <= sx_s6 + (SW'(pax2_s6) << (2 * CH));
			sy_s7   <= sy_s6 + (SW'(pay2_s6) << (2 * CH));
		end
	end

	// ---------------- stage 8: drop fraction of t, add start point ----------------
	logic [AW-1:0] mx_c, my_c;

	assign mx_c = {2'b00, sx_s7[SW-1:TF]};
	assign my_c = {2'b00, sy_s7[SW-1:TF]};

	always_ff @(posedge clk) begin
		if (en) begin
			par_s8 <= par_s7;
			px_s8  <= {{(AW-W){x1_s7[W-1]}}, x1_s7} + (xn_s7 ? (~mx_c + 1'b1) : mx_c);
			py_s8  <= {{(AW-W){y1_s7[W-1]}}, y1_s7} + (yn_s7 ? (~my_c + 1'b1) : my_c);
		end
	end

	// ---------------- saturate ----------------
	logic                ox_c, oy_c;
	logic signed [W-1:0] cx_c, cy_c, smax_c, smin_c;
	logic                ovf_c;

	assign smax_c = {1'b0, {(W-1){1'b1}}};
	assign smin_c = {1'b1, {(W-1){1'b0}}};
	assign ox_c   = !((&px_s8[AW-1:W-1]) || !(|px_s8[AW-1:W-1]));
	assign oy_c   = !((&py_s8[AW-1:W-1]) || !(|py_s8[AW-1:W-1]));
	assign cx_c   = par_s8 ? '0 : ox_c ? (px_s8[AW-1] ? smin_c : smax_c) : px_s8[W-1:0];
	assign cy_c   = par_s8 ? '0 : oy_c ? (py_s8[AW-1] ? smin_c : smax_c) : py_s8[W-1:0];
	assign ovf_c  = !par_s8 && (ox_c || oy_c);

	// ---------------- output register and skid ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q  <= 1'b0;
			sk_v_q <= 1'b0;
		end else if (!o_v_q || result.ready) begin
			o_v_q  <= sk_v_q || deliver;
			sk_v_q <= 1'b0;
		end else if (deliver) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!o_v_q || result.ready) begin
			if (sk_v_q) begin
				o_cx_q  <= sk_cx_q;
				o_cy_q  <= sk_cy_q;
				o_par_q <= sk_par_q;
				o_ovf_q <= sk_ovf_q;
			end else begin
				o_cx_q  <= cx_c;
				o_cy_q  <= cy_c;
				o_par_q <= par_s8;
				o_ovf_q <= ovf_c;
			end
		end else if (deliver) begin
			sk_cx_q  <= cx_c;
			sk_cy_q  <= cy_c;
			sk_par_q <= par_s8;
			sk_ovf_q <= ovf_c;
		end
	end

	assign result.valid       = o_v_q;
	assign result.cross_x     = o_cx_q;
	assign result.cross_y     = o_cy_q;
	assign result.is_parallel = o_par_q;
	assign result.overflowed  = o_ovf_q;

	// ---------------- assertions ----------------
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> o_v_q)
		else $error("skid holds a result while the output register is empty");

	a_parallel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.is_parallel |->
			result.cross_x == '0 && result.cross_y == '0 && !result.overflowed)
		else $error("parallel result carries a point or an overflow");

	a_ovf_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.overflowed |->
			result.cross_x == smax_c || result.cross_x == smin_c ||
			result.cross_y == smax_c || result.cross_y == smin_c)
		else $error("overflow flagged without a clamped coordinate");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks line_line_intersection_core against an exact wide-integer model of
// the intersection point. Directed geometry cases come first, then random
// lines under three patterns of source and sink idling.
// ----------------------------------------------------------------------------
module tb;

	localparam int CW = 32;
	localparam int PIPE_DEPTH = 4 * CW + 35 + 10;
	localparam longint CYCLE_LIMIT = 64'd2000000;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [511:0] wide_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   par;
		logic   ovf;
	} point_t;

	logic clk;
	logic arst_n;
	lli_query_if #(.COORD_WIDTH(CW)) query ();
	lli_result_if #(.COORD_WIDTH(CW)) result ();

	line_line_intersection_core #(.COORD_WIDTH(CW)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.query(query.sink),
		.result(result.source)
	);

	point_t expected_points[$];
	int send_idle_pct;
	int recv_idle_pct;
	int errors;
	longint cycles;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic wide_t trunc_div(wide_t n, wide_t d);
		wide_t an;
		wide_t ad;
		wide_t q;
		begin
			an = n < 0 ? -n : n;
			ad = d < 0 ? -d : d;
			q = an / ad;
			return ((n < 0) != (d < 0)) ? -q : q;
		end
	endfunction

	function automatic wide_t shr32_trunc(wide_t v);
		wide_t a;
		begin
			a = v < 0 ? -v : v;
			a = a >>> 32;
			return v < 0 ? -a : a;
		end
	endfunction

	function automatic coord_t clamp(wide_t v, inout logic ovf);
		wide_t hi;
		wide_t lo;
		begin
			hi = (wide_t'(1) <<< (CW - 1)) - 1;
			lo = -(wide_t'(1) <<< (CW - 1));
			if (v > hi) begin
				ovf = 1'b1;
				return coord_t'(hi);
			end
			if (v < lo) begin
				ovf = 1'b1;
				return coord_t'(lo);
			end
			return coord_t'(v);
		end
	endfunction

	function automatic point_t cross_point(coord_t c[8]);
		wide_t ax, ay, dx1, dy1, dx2, dy2, den, num, t;
		point_t p;
		logic ovf;
		begin
			ax = c[0];
			ay = c[1];
			dx1 = wide_t'(c[2]) - ax;
			dy1 = wide_t'(c[3]) - ay;
			dx2 = wide_t'(c[6]) - wide_t'(c[4]);
			dy2 = wide_t'(c[7]) - wide_t'(c[5]);
			den = dx2 * dy1 - dx1 * dy2;
			p = '0;
			if (den == 0) begin
				p.par = 1'b1;
				return p;
			end
			num = dx2 * (wide_t'(c[5]) - ay) - dy2 * (wide_t'(c[4]) - ax);
			t = trunc_div(num <<< 32, den);
			ovf = 1'b0;
			p.x = clamp(ax + shr32_trunc(t * dx1), ovf);
			p.y = clamp(ay + shr32_trunc(t * dy1), ovf);
			p.ovf = ovf;
			return p;
		end
	endfunction

	task automatic send_lines(coord_t c[8]);
		begin
			while ($urandom_range(99) < send_idle_pct) begin
				query.valid <= 1'b0;
				@(posedge clk);
			end
			query.valid <= 1'b1;
			query.l1a_x <= c[0];
			query.l1a_y <= c[1];
			query.l1b_x <= c[2];
			query.l1b_y <= c[3];
			query.l2a_x <= c[4];
			query.l2a_y <= c[5];
			query.l2b_x <= c[6];
			query.l2b_y <= c[7];
			expected_points.push_back(cross_point(c));
			do @(posedge clk); while (!query.ready);
		end
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(5))
			0: return coord_t'($urandom);
			1: return coord_t'($signed($urandom_range(2000)) - 1000) <<< 16;
			2: return coord_t'($urandom_range(65535) - 32768);
			3: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			default: return coord_t'($signed($urandom_range(131071)) - 65536) <<< 8;
		endcase
	endfunction

	task automatic test_directed();
		coord_t c[8];
		coord_t ext[4];
		begin
			ext = '{32'sh7fffffff, 32'sh80000000, 32'sh0, 32'shffffffff};
			c = '{0, 0, 32'sh10000, 32'sh10000, 0, 32'sh10000, 32'sh10000, 0};
			send_lines(c);
			c = '{0, 0, 32'sh10000, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000};
			send_lines(c);
			c = '{5, 5, 5, 5, 1, 2, 3, 4};
			send_lines(c);
			c = '{0, 0, 0, 0, 0, 0, 0, 0};
			send_lines(c);
			c = '{0, 0, 1, 0, 32'sh7fff0000, 0, 32'sh7fff0000, 1};
			send_lines(c);
			c = '{0, 0, -1, 0, 32'sh80000000, 0, 32'sh80000000, 1};
			send_lines(c);
			c = '{0, 0, 1, 1, 32'sh7fffffff, 0, 32'sh7fffffff, 1};
			send_lines(c);
			c = '{0, 0, 3, 1, 0, 1, 1, 0};
			send_lines(c);
			c = '{0, 0, -3, 1, 0, 1, -1, 0};
			send_lines(c);
			for (int i = 0; i < 12; i++) begin
				foreach (c[k]) c[k] = ext[$urandom_range(3)];
				send_lines(c);
			end
		end
	endtask

	task automatic test_random(int n);
		coord_t c[8];
		begin
			for (int i = 0; i < n; i++) begin
				foreach (c[k]) c[k] = rand_coord();
				if ($urandom_range(9) == 0) begin
					c[6] = c[4] + (c[2] - c[0]);
					c[7] = c[5] + (c[3] - c[1]);
				end
				send_lines(c);
			end
		end
	endtask

	task automatic drain();
		begin
			query.valid <= 1'b0;
			while (expected_points.size() != 0) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
		result.ready <= ($urandom_range(99) >= recv_idle_pct);
		if (result.valid && result.ready) begin
			if (expected_points.size() == 0) begin
				$error("transfer with no expected result");
				errors++;
			end else begin
				point_t e;
				e = expected_points.pop_front();
				if (result.cross_x !== e.x) begin
					$error("cross_x expected %0d actual %0d", e.x, result.cross_x);
					errors++;
				end
				if (result.cross_y !== e.y) begin
					$error("cross_y expected %0d actual %0d", e.y, result.cross_y);
					errors++;
				end
				if (result.is_parallel !== e.par) begin
					$error("is_parallel expected %0b actual %0b", e.par, result.is_parallel);
					errors++;
				end
				if (result.overflowed !== e.ovf) begin
					$error("overflowed expected %0b actual %0b", e.ovf, result.overflowed);
					errors++;
				end
			end
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		send_idle_pct = 29;
		recv_idle_pct = 74;
		arst_n = 1'b0;
		query.valid = 1'b0;
		query.l1a_x = '0;
		query.l1a_y = '0;
		query.l1b_x = '0;
		query.l1b_y = '0;
		query.l2a_x = '0;
		query.l2a_y = '0;
		query.l2b_x = '0;
		query.l2b_y = '0;
		result.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(530);
		drain();
		send_idle_pct = 74;
		recv_idle_pct = 29;
		test_random(550);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(550);
		drain();
		repeat (PIPE_DEPTH) @(posedge clk);
		if (errors == 0 && expected_points.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/lli_pkg.sv
hw/rtl/lli_query_if.sv
hw/rtl/lli_result_if.sv
hw/rtl/line_line_intersection_core.sv
tb/tb.sv
